@@ sv/spl_pkg.sv @@
// Package for the sorted positional list unit.
// Holds the data width, default depth, operation and status codes and the
// command struct that the control logic broadcasts to the row of cells.
package spl_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_SORTED = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSPOS = 3'd2,
        OP_DELPOS = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell in the cycle a transaction is accepted
    typedef struct packed {
        logic                     ins_en;
        logic                     del_en;
        logic                     rd_en;
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

@@ sv/sorted_positional_list_unit.sv @@
// Top level of the sorted positional list unit: control, result register
// and the row of spl_cell slots. Depends on spl_pkg and spl_cell.
//
// A bounded list of up to DEPTH signed 32-bit entries, operated on by one
// transaction at a time: sorted insert, append, insert at position, delete
// at position and read. Each transaction is applied in the cycle it is
// accepted and its result is registered into the output register, so the
// unit takes one transaction per cycle as long as its results are taken;
// a new transaction is accepted while the previous result is taken. All
// slots compare and shift together in that cycle, and the longest path is
// the insertion mark rippling through the DEPTH cells. A result reports the
// count after the operation, an empty flag and a status: done, position out
// of range (ignored) or list full (dropped). Positions are one-based and
// valid from 1 to the current count only.
module sorted_positional_list_unit #(
    parameter int DEPTH = spl_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [spl_pkg::OP_W-1:0]          operation,
    input  logic signed [spl_pkg::DATA_W-1:0] value,
    input  logic [CNT_W-1:0]                  position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [spl_pkg::DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]                  count,
    output logic                              is_empty,
    output logic [1:0]                        status
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                              accept;
    logic                              full;
    logic                              pos_ok;
    spl_pkg::op_t                      op;
    spl_pkg::cmd_t                     cmd;
    spl_pkg::status_t                  st;
    logic                              do_ins;
    logic                              do_del;
    logic                              do_rd;

    logic [CNT_W-1:0]                  entry_count_reg;
    logic [CNT_W-1:0]                  entry_count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [spl_pkg::DATA_W-1:0] read_value_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic                              is_empty_reg;
    spl_pkg::status_t                  status_reg;

    logic signed [spl_pkg::DATA_W-1:0] entry_w [0:DEPTH+1];
    logic                              valid_w [0:DEPTH+1];
    logic                              pre_w   [0:DEPTH];
    logic [spl_pkg::DATA_W-1:0]        rd_w    [0:DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign op       = spl_pkg::op_t'(operation);
    assign full     = (entry_count_reg == FULL_CNT);
    assign pos_ok   = (position != '0) && (position <= entry_count_reg);

    // Decode the operation and check range and fullness
    always_comb
    begin
        st     = spl_pkg::ST_DONE;
        do_ins = 1'b0;
        do_del = 1'b0;
        do_rd  = 1'b0;
        case (op)
            spl_pkg::OP_SORTED, spl_pkg::OP_APPEND:
            begin
                if (full)
                    st = spl_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            spl_pkg::OP_INSPOS:
            begin
                if (!pos_ok)
                    st = spl_pkg::ST_RANGE;
                else if (full)
                    st = spl_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            spl_pkg::OP_DELPOS:
            begin
                if (!pos_ok)
                    st = spl_pkg::ST_RANGE;
                else
                    do_del = 1'b1;
            end
            spl_pkg::OP_READ:
            begin
                if (!pos_ok)
                    st = spl_pkg::ST_RANGE;
                else
                    do_rd = 1'b1;
            end
            default:
            begin
                st = spl_pkg::ST_DONE;
            end
        endcase
    end

    // Broadcast the command to the cells only for an accepted transaction
    always_comb
    begin
        cmd.ins_en = accept && do_ins;
        cmd.del_en = accept && do_del;
        cmd.rd_en  = accept && do_rd;
        cmd.op     = op;
        cmd.value  = value;
    end

    // Advance the entry count
    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (cmd.ins_en)
            entry_count_next = entry_count_reg + CNT_W'(1);
        else if (cmd.del_en)
            entry_count_next = entry_count_reg - CNT_W'(1);
    end

    // Hold a result until it is taken
    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= rd_w[DEPTH];
            count_reg      <= entry_count_next;
            is_empty_reg   <= (entry_count_next == '0);
            status_reg     <= st;
        end
    end

    // Ends of the row
    assign entry_w[0]       = '0;
    assign valid_w[0]       = 1'b0;
    assign entry_w[DEPTH+1] = '0;
    assign valid_w[DEPTH+1] = 1'b0;
    assign pre_w[0]         = 1'b0;
    assign rd_w[0]          = '0;

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spl_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .position    (position),
            .left_entry  (entry_w[i]),
            .left_valid  (valid_w[i]),
            .right_entry (entry_w[i+2]),
            .right_valid (valid_w[i+2]),
            .pre_in      (pre_w[i]),
            .pre_out     (pre_w[i+1]),
            .rd_in       (rd_w[i]),
            .rd_out      (rd_w[i+1]),
            .entry       (entry_w[i+1]),
            .valid       (valid_w[i+1])
        );
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;
    assign is_empty   = is_empty_reg;
    assign status     = status_reg;

endmodule

@@ sv/spl_cell.sv @@
// One list slot of the sorted positional list unit.
// Holds an entry and its valid flag; shifts with its neighbors on insert and
// delete. Depends on spl_pkg.
module spl_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spl_pkg::cmd_t                    cmd,
    input  logic [CNT_W-1:0]                 position,
    input  logic signed [spl_pkg::DATA_W-1:0] left_entry,
    input  logic                             left_valid,
    input  logic signed [spl_pkg::DATA_W-1:0] right_entry,
    input  logic                             right_valid,
    input  logic                             pre_in,
    output logic                             pre_out,
    input  logic [spl_pkg::DATA_W-1:0]       rd_in,
    output logic [spl_pkg::DATA_W-1:0]       rd_out,
    output logic signed [spl_pkg::DATA_W-1:0] entry,
    output logic                             valid
);

    // One-based position of this slot
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX + 1);

    logic signed [spl_pkg::DATA_W-1:0] entry_reg;
    logic signed [spl_pkg::DATA_W-1:0] entry_next;
    logic                              valid_reg;
    logic                              valid_next;
    logic                              stop;
    logic                              pos_hit;

    assign pos_hit = (position == MY_POS);

    // Insertion stops at the first free slot, or earlier at the first entry
    // not below the value (sorted) or at the addressed slot (positional)
    always_comb
    begin
        stop = !valid_reg;
        case (cmd.op)
            spl_pkg::OP_SORTED: stop = stop || (entry_reg >= cmd.value);
            spl_pkg::OP_INSPOS: stop = stop || pos_hit;
            default:            stop = !valid_reg;
        endcase
    end

    // Pass the stop mark down the row: every later slot shifts back
    assign pre_out = pre_in || stop;

    // Fold the addressed entry into the read bus
    assign rd_out = rd_in | ((cmd.rd_en && pos_hit) ? entry_reg : '0);

    // Next slot contents
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.ins_en)
        begin
            if (pre_in)
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
            else if (stop)
            begin
                entry_next = cmd.value;
                valid_next = 1'b1;
            end
        end
        else if (cmd.del_en && (position <= MY_POS))
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the entry value
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

@@ sv/spl_checker.sv @@
// Port-level checker for the sorted positional list unit, with its bind.
// Depends on spl_pkg and sorted_positional_list_unit.
module spl_checker #(
    parameter int DEPTH = spl_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [spl_pkg::DATA_W-1:0] read_value,
    input logic [CNT_W-1:0]                  count,
    input logic                              is_empty,
    input logic [1:0]                        status
);

    // An accepted transaction yields a result in the next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction gave no result");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(count)
            && $stable(is_empty) && $stable(status))
        else $error("stalled result changed");

    // Empty flag follows the count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    // A dropped insert only happens on a full list
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spl_pkg::ST_FULL) |-> (count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // Read data only comes with a completed transaction
    a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_value != '0) |-> (status == spl_pkg::ST_DONE))
        else $error("read data on a failed transaction");

endmodule

bind sorted_positional_list_unit spl_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_spl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status)
);
